// ===== rtl/graph_reachability_engine_top_macros.svh =====
// Assertion macros for the graph reachability engine.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef GRAPH_REACHABILITY_ENGINE_TOP_MACROS_SVH
`define GRAPH_REACHABILITY_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define GRE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GRE_ASSERT_SAME(lbl, ante, cons, msg)
`define GRE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/gre_pkg.sv =====
`timescale 1ns / 1ps

package gre_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int KEY_W        = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_VERTEX = 2'd0,
        OP_ADD_EDGE   = 2'd1,
        OP_QUERY      = 2'd2,
        OP_NONE       = 2'd3
    } cmd_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // One classified item as it travels from the front part to the back part.
    typedef struct packed {
        cmd_op_t                  op;
        logic signed [KEY_W-1:0]  first_key;
        logic signed [KEY_W-1:0]  second_key;
    } cmd_t;

endpackage

// ===== rtl/gre_front.sv =====
`timescale 1ns / 1ps

module gre_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [gre_pkg::OP_W-1:0]         operation,
    input  logic signed [gre_pkg::KEY_W-1:0] first_key,
    input  logic signed [gre_pkg::KEY_W-1:0] second_key,
    output logic                             cmd_valid,
    output gre_pkg::cmd_t                    cmd,
    input  logic                             cmd_take
);
    import gre_pkg::*;

    // Two-entry command queue between the input side and the executor.
    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       new_cmd;

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        new_cmd.op         = cmd_op_t'(operation);
        new_cmd.first_key  = first_key;
        new_cmd.second_key = second_key;
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== rtl/gre_back.sv =====
`timescale 1ns / 1ps

module gre_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    input  gre_pkg::cmd_t                    cmd,
    output logic                             cmd_take,
    input  logic                             pop,
    output logic                             empty,
    output logic [gre_pkg::STATUS_W-1:0]     status,
    output logic                             path_exists
);
    import gre_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_POP,
        S_CHECK,
        S_PUSH
    } state_t;

    typedef logic [MAX_VERTICES-1:0] row_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    cmd_op_t                 op_reg, op_next;
    logic [KEY_W-1:0]        k1_reg, k1_next;
    logic [KEY_W-1:0]        k2_reg, k2_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]        rd_slot_reg, rd_slot_next;
    logic                    a_fnd_reg, a_fnd_next;
    logic                    b_fnd_reg, b_fnd_next;
    logic [IDX_W-1:0]        a_reg, a_next;
    logic [IDX_W-1:0]        b_reg, b_next;
    row_t                    visited_reg, visited_next;
    logic [CNT_W-1:0]        depth_reg, depth_next;
    row_t                    adj_reg [MAX_VERTICES];
    row_t                    adj_next [MAX_VERTICES];
    logic                    res_vld_reg, res_vld_next;
    status_t                 res_st_reg, res_st_next;
    logic                    res_path_reg, res_path_next;

    // Vertex key table and worklist, both with registered reads.
    logic [KEY_W-1:0]        keys_mem [MAX_VERTICES];
    logic [KEY_W-1:0]        key_rd_reg;
    logic                    key_we;
    logic                    key_re;
    logic [IDX_W-1:0]        stack_mem [MAX_VERTICES];
    logic [IDX_W-1:0]        stk_rd_reg;
    logic                    stk_we;
    logic                    stk_re;
    logic [IDX_W-1:0]        stk_wa;
    logic [IDX_W-1:0]        stk_wd;
    logic [IDX_W-1:0]        stk_ra;

    logic                    res_free;
    logic                    scan_more;
    row_t                    cand;

    function automatic logic [IDX_W-1:0] lowest_bit(input row_t v);
        logic [IDX_W-1:0] sel;
        sel = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                sel = IDX_W'(i);
            end
        end
        return sel;
    endfunction

    assign empty       = !res_vld_reg;
    assign status      = res_st_reg;
    assign path_exists = res_path_reg;

    assign res_free  = !res_vld_reg || pop;
    assign scan_more = (idx_reg < cnt_reg);
    assign cand      = adj_reg[stk_rd_reg] & ~visited_reg;
    assign stk_ra    = IDX_W'(depth_reg - CNT_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        k1_next       = k1_reg;
        k2_next       = k2_reg;
        idx_next      = idx_reg;
        rd_vld_next   = rd_vld_reg;
        rd_slot_next  = rd_slot_reg;
        a_fnd_next    = a_fnd_reg;
        b_fnd_next    = b_fnd_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        visited_next  = visited_reg;
        depth_next    = depth_reg;
        adj_next      = adj_reg;
        res_vld_next  = res_vld_reg;
        res_st_next   = res_st_reg;
        res_path_next = res_path_reg;
        cmd_take      = 1'b0;
        key_we        = 1'b0;
        key_re        = 1'b0;
        stk_we        = 1'b0;
        stk_re        = 1'b0;
        stk_wa        = '0;
        stk_wd        = a_reg;

        if (pop && res_vld_reg)
        begin
            res_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // A command is only taken when the result slot will be free.
                if (cmd_valid && res_free)
                begin
                    cmd_take = 1'b1;
                    unique case (cmd.op)
                        OP_ADD_VERTEX:
                        begin
                            res_vld_next  = 1'b1;
                            res_path_next = 1'b0;
                            if (cnt_reg == CNT_W'(MAX_VERTICES))
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                key_we      = 1'b1;
                                cnt_next    = cnt_reg + CNT_W'(1);
                                res_st_next = ST_OK;
                            end
                        end
                        OP_ADD_EDGE, OP_QUERY:
                        begin
                            op_next     = cmd.op;
                            k1_next     = cmd.first_key;
                            k2_next     = cmd.second_key;
                            idx_next    = '0;
                            rd_vld_next = 1'b0;
                            a_fnd_next  = 1'b0;
                            b_fnd_next  = 1'b0;
                            state_next  = S_SEARCH;
                        end
                        default:
                        begin
                            res_vld_next  = 1'b1;
                            res_st_next   = ST_OK;
                            res_path_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // One table read per cycle; each compare follows in the next cycle, on the registered key.
                rd_vld_next = scan_more;
                if (scan_more)
                begin
                    key_re       = 1'b1;
                    rd_slot_next = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!a_fnd_reg && key_rd_reg == k1_reg)
                    begin
                        a_fnd_next = 1'b1;
                        a_next     = rd_slot_reg;
                    end
                    if (!b_fnd_reg && key_rd_reg == k2_reg)
                    begin
                        b_fnd_next = 1'b1;
                        b_next     = rd_slot_reg;
                    end
                end
                if (!scan_more && !rd_vld_reg)
                begin
                    if (!a_fnd_reg || !b_fnd_reg)
                    begin
                        res_vld_next  = 1'b1;
                        res_st_next   = ST_NOT_FOUND;
                        res_path_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else if (op_reg == OP_ADD_EDGE)
                    begin
                        adj_next[a_reg][b_reg] = 1'b1;
                        adj_next[b_reg][a_reg] = 1'b1;
                        res_vld_next  = 1'b1;
                        res_st_next   = ST_OK;
                        res_path_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else if (a_reg == b_reg)
                    begin
                        res_vld_next  = 1'b1;
                        res_st_next   = ST_OK;
                        res_path_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        visited_next        = '0;
                        visited_next[a_reg] = 1'b1;
                        stk_we              = 1'b1;
                        stk_wa              = '0;
                        stk_wd              = a_reg;
                        depth_next          = CNT_W'(1);
                        state_next          = S_POP;
                    end
                end
            end

            S_POP:
            begin
                if (depth_reg == '0)
                begin
                    res_vld_next  = 1'b1;
                    res_st_next   = ST_OK;
                    res_path_next = 1'b0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    stk_re     = 1'b1;
                    depth_next = depth_reg - CNT_W'(1);
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (stk_rd_reg == b_reg)
                begin
                    res_vld_next  = 1'b1;
                    res_st_next   = ST_OK;
                    res_path_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                // Neighbors go onto the worklist lowest slot first, one per cycle.
                if (cand == '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    visited_next[lowest_bit(cand)] = 1'b1;
                    stk_we     = 1'b1;
                    stk_wa     = depth_reg[IDX_W-1:0];
                    stk_wd     = lowest_bit(cand);
                    depth_next = depth_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            op_reg       <= OP_NONE;
            k1_reg       <= '0;
            k2_reg       <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_slot_reg  <= '0;
            a_fnd_reg    <= 1'b0;
            b_fnd_reg    <= 1'b0;
            a_reg        <= '0;
            b_reg        <= '0;
            visited_reg  <= '0;
            depth_reg    <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
            res_vld_reg  <= 1'b0;
            res_st_reg   <= ST_OK;
            res_path_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            op_reg       <= op_next;
            k1_reg       <= k1_next;
            k2_reg       <= k2_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            rd_slot_reg  <= rd_slot_next;
            a_fnd_reg    <= a_fnd_next;
            b_fnd_reg    <= b_fnd_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            visited_reg  <= visited_next;
            depth_reg    <= depth_next;
            adj_reg      <= adj_next;
            res_vld_reg  <= res_vld_next;
            res_st_reg   <= res_st_next;
            res_path_reg <= res_path_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            keys_mem[cnt_reg[IDX_W-1:0]] <= cmd.first_key;
        end
        if (key_re)
        begin
            key_rd_reg <= keys_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stack_mem[stk_ra];
        end
    end

endmodule

// ===== rtl/graph_reachability_engine_top.sv =====
// The executor works on one item at a time and takes no new command until the last one is done; an
// edge or query item first scans the key table, and a query may then walk the graph with the worklist.
// Reset: rst_n is asynchronous and active low; it clears the table, edges, command queue and result register.
`timescale 1ns / 1ps

module graph_reachability_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [gre_pkg::OP_W-1:0]         operation,
    input  logic signed [gre_pkg::KEY_W-1:0] first_key,
    input  logic signed [gre_pkg::KEY_W-1:0] second_key,
    output logic                             empty,
    input  logic                             pop,
    output logic [gre_pkg::STATUS_W-1:0]     status,
    output logic                             path_exists
);
    import gre_pkg::*;

    `include "graph_reachability_engine_top_macros.svh"

    // The front part takes each item into a two-entry command queue and turns the
    // operation field into a command code. The back part pulls one command at a time,
    // resolves keys by scanning the vertex table one slot per cycle, appends vertices to
    // the table, updates the adjacency matrix, or walks the graph depth first with an
    // explicit worklist. Its single result register stands between the executor and the
    // result side, so the front part keeps accepting items, until its queue is full, while a result waits to be popped.
    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    gre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .first_key  (first_key),
        .second_key (second_key),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    gre_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take),
        .pop         (pop),
        .empty       (empty),
        .status      (status),
        .path_exists (path_exists)
    );

    // The executor never takes a command from an empty queue.
    `GRE_ASSERT_SAME(a_take_needs_cmd, cmd_take, cmd_valid, "command taken from empty queue")

    // A full command queue always has a command waiting for the executor.
    `GRE_ASSERT_SAME(a_full_has_cmd, full, cmd_valid, "queue full without a pending command")

    // Only a successful query can report a path.
    `GRE_ASSERT_SAME(a_path_only_ok, !empty && path_exists, status == ST_OK, "path with error")

    // A waiting result that is not popped stays valid with its status unchanged.
    `GRE_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(status), "result lost")

endmodule

// ===== dv/graph_reachability_engine_top_test.sv =====
`timescale 1ns / 1ps

module graph_reachability_engine_top_test;
    import gre_pkg::*;

    // Key extremes used by the directed items and by random vertex inserts.
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // Number of random items in each of the three idling phases.
    localparam int PHASE_ITEMS = 567;

    // One expected answer: the status code and the path flag.
    typedef struct packed {
        status_t code;
        logic    path;
    } reach_answer_t;

    // The scoreboard keeps its own copy of the vertex table and of the adjacency
    // matrix. Every accepted item is applied to that copy and the answer that it
    // produces is queued; every accepted result is checked against the oldest
    // queued answer.
    class reach_scoreboard;
        logic [KEY_W-1:0]        slot_keys [MAX_VERTICES];
        int                      used_slots = 0;
        logic [MAX_VERTICES-1:0] links [MAX_VERTICES] = '{default: '0};
        reach_answer_t           awaited [$];
        int                      errors = 0;

        // The lowest slot holding the key wins, so duplicate keys resolve to the
        // first copy. Returns -1 when the key is not in the table.
        function int lookup_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < used_slots; i++)
                if (slot_keys[i] == key)
                    return i;
            return -1;
        endfunction

        // Depth-first walk over the adjacency matrix with an explicit stack.
        // A slot is marked when it is pushed, so no slot is pushed twice.
        function bit path_found(int src, int dst);
            logic [MAX_VERTICES-1:0] seen;
            int                      stack [MAX_VERTICES];
            int                      depth;
            int                      cur;
            if (src == dst)
                return 1'b1;
            seen      = '0;
            seen[src] = 1'b1;
            stack[0]  = src;
            depth     = 1;
            while (depth > 0) begin
                depth--;
                cur = stack[depth];
                if (cur == dst)
                    return 1'b1;
                for (int j = 0; j < used_slots; j++) begin
                    if (links[cur][j] && !seen[j]) begin
                        seen[j]      = 1'b1;
                        stack[depth] = j;
                        depth++;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_item(cmd_op_t op, logic [KEY_W-1:0] k1, logic [KEY_W-1:0] k2);
            reach_answer_t ans;
            int            a;
            int            b;
            ans.code = ST_OK;
            ans.path = 1'b0;
            case (op)
                OP_ADD_VERTEX: begin
                    if (used_slots >= MAX_VERTICES) begin
                        ans.code = ST_FULL;
                    end
                    else begin
                        slot_keys[used_slots] = k1;
                        used_slots++;
                    end
                end
                OP_ADD_EDGE, OP_QUERY: begin
                    a = lookup_slot(k1);
                    b = lookup_slot(k2);
                    if (a < 0 || b < 0) begin
                        ans.code = ST_NOT_FOUND;
                    end
                    else if (op == OP_ADD_EDGE) begin
                        links[a][b] = 1'b1;
                        links[b][a] = 1'b1;
                    end
                    else begin
                        ans.path = path_found(a, b);
                    end
                end
                default: ;
            endcase
            awaited.insert(awaited.size(), ans);
        endfunction

        function void check_result(logic [STATUS_W-1:0] code, logic path);
            reach_answer_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, status %0d path_exists %0b",
                         $time, code, path);
                return;
            end
            want = awaited.pop_front();
            if (code !== want.code) begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.code, code);
            end
            if (path !== want.path) begin
                errors++;
                $display("%0t: path_exists mismatch, expected %0b, actual %0b",
                         $time, want.path, path);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] first_key;
    logic signed [KEY_W-1:0] second_key;
    logic                    empty;
    logic                    pop;
    logic [STATUS_W-1:0]     status;
    logic                    path_exists;

    reach_scoreboard sb = new;

    // Idle chances in percent, changed from phase to phase.
    int send_idle_pct = 29;
    int recv_idle_pct = 46;

    // Keys the stimulus has put into the table (duplicates included). Lookups
    // mostly pick from here so that edges and queries reach real vertices.
    logic signed [KEY_W-1:0] known_keys [$];

    graph_reachability_engine_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .first_key   (first_key),
        .second_key  (second_key),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .path_exists (path_exists)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. The slowest correct run takes well under a tenth
    // of this.
    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Both handshakes are sampled at the clock edge, where every input still
    // holds the value driven before the edge and every output still holds its
    // value from the previous cycle.
    always @(posedge clk) begin
        if (rst_n) begin
            if (push && !full)
                sb.note_item(cmd_op_t'(operation), first_key, second_key);
            if (pop && !empty)
                sb.check_result(status, path_exists);
        end
    end

    // The result side pops at random according to the current idle chance.
    initial begin
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one item, after a random gap, and returns at the edge where it is
    // taken. Push stays high into the next item when no gap follows.
    task automatic send_item(input cmd_op_t op, input logic signed [KEY_W-1:0] k1,
                             input logic signed [KEY_W-1:0] k2);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        operation  <= op;
        first_key  <= k1;
        second_key <= k2;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (op == OP_ADD_VERTEX && known_keys.size() < MAX_VERTICES)
            known_keys.insert(known_keys.size(), k1);
    endtask

    // Stops sending and waits until every expected result has been popped.
    // The first edge lets the monitor note an item taken at the last edge.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Mostly a key already in the table; now and then a random one, which is
    // almost never present and so gives a key-not-found answer.
    function automatic logic signed [KEY_W-1:0] pick_key();
        if (known_keys.size() == 0 || $urandom_range(9) == 0)
            return $urandom;
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    // Queries dominate so that the walk sees many graph shapes. Edges are rare,
    // which keeps the graph from becoming fully connected early in the run.
    task automatic random_item();
        int                      roll;
        logic signed [KEY_W-1:0] k;
        roll = $urandom_range(99);
        if (roll < 4) begin
            case ($urandom_range(4))
                0:       k = pick_key();
                1:       k = $urandom_range(1) ? KEY_MIN : KEY_MAX;
                default: k = $urandom;
            endcase
            send_item(OP_ADD_VERTEX, k, $urandom);
        end
        else if (roll < 6) begin
            send_item(OP_ADD_EDGE, pick_key(), pick_key());
        end
        else if (roll < 8) begin
            send_item(OP_NONE, $urandom, $urandom);
        end
        else begin
            send_item(OP_QUERY, pick_key(), pick_key());
        end
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) begin
            random_item();
            // Now and then the sender holds off until the block is empty.
            if ($urandom_range(199) == 0)
                drain();
        end
        drain();
    endtask

    initial begin
        push       <= 1'b0;
        operation  <= OP_NONE;
        first_key  <= '0;
        second_key <= '0;
        rst_n      <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items. An empty table makes every lookup fail, and the
        // unused operation must answer ok with no path.
        send_item(OP_QUERY, 1, 2);
        send_item(OP_ADD_EDGE, KEY_MIN, KEY_MAX);
        send_item(OP_NONE, KEY_MIN, KEY_MAX);
        // Extreme keys, plus a duplicate of zero that lookups must never reach.
        send_item(OP_ADD_VERTEX, KEY_MIN, 0);
        send_item(OP_ADD_VERTEX, KEY_MAX, 0);
        send_item(OP_ADD_VERTEX, 0, -1);
        send_item(OP_ADD_VERTEX, -1, KEY_MAX);
        send_item(OP_ADD_VERTEX, 0, KEY_MIN);
        // A vertex always reaches itself, even with no edges.
        send_item(OP_QUERY, KEY_MIN, KEY_MIN);
        send_item(OP_QUERY, KEY_MIN, KEY_MAX);
        send_item(OP_ADD_EDGE, KEY_MIN, KEY_MAX);
        send_item(OP_QUERY, KEY_MAX, KEY_MIN);
        // A self loop must not create any path.
        send_item(OP_ADD_EDGE, 0, 0);
        send_item(OP_QUERY, 0, -1);
        // Adding an existing edge again is accepted and changes nothing.
        send_item(OP_ADD_EDGE, KEY_MIN, KEY_MAX);
        // An unknown key on either side is an error.
        send_item(OP_ADD_EDGE, KEY_MAX, 12345);
        send_item(OP_QUERY, 777, -1);
        // A chain of edges from KEY_MIN through KEY_MAX and -1 to 0 makes the walk go several levels deep.
        send_item(OP_ADD_EDGE, KEY_MAX, -1);
        send_item(OP_ADD_EDGE, -1, 0);
        send_item(OP_QUERY, KEY_MIN, 0);
        send_item(OP_NONE, -1, -1);
        drain();

        // Sender idles less than the receiver, then the other way round.
        run_phase(29, 46, PHASE_ITEMS);
        run_phase(46, 29, PHASE_ITEMS);

        // Make sure the table is full and that one more insert is refused.
        while (known_keys.size() < MAX_VERTICES)
            send_item(OP_ADD_VERTEX, $urandom, $urandom);
        send_item(OP_ADD_VERTEX, KEY_MAX, 0);
        drain();

        // Both sides at full rate.
        run_phase(0, 0, PHASE_ITEMS);

        // Give the block time to show any result that was never expected.
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gre_pkg.sv
rtl/gre_front.sv
rtl/gre_back.sv
rtl/graph_reachability_engine_top.sv
dv/graph_reachability_engine_top_test.sv
